// File: hw/rtl/tmpf_pkg.sv
// Shared types and constants of the touch median press filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tmpf_pkg;

    // Readings of one transaction
    localparam int NUM_RD = 5;
    localparam int RD_W   = 12;
    localparam int RANK_W = $clog2(NUM_RD);
    localparam logic [RANK_W-1:0] MID_RANK = RANK_W'(NUM_RD / 2);

    // Screen geometry and calibration
    localparam logic [11:0] SCREEN_WIDTH  = 12'd480;
    localparam logic [11:0] SCREEN_HEIGHT = 12'd320;
    localparam logic [2:0]  GROUP_SIZE    = 3'd5;
    localparam logic [11:0] X_OFFSET      = 12'd300;
    localparam logic [11:0] Y_OFFSET      = 12'd200;
    localparam logic [11:0] SPAN          = 12'd3600;

    // Divide by SPAN: multiply by floor(2^RECIP_SHIFT / SPAN), then one correction step
    localparam int MAG_W       = 24;
    localparam int QUOT_W      = 13;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SPAN));
    localparam int PROD_W      = MAG_W + RECIP_W;

    // Register reset values
    localparam logic [11:0] PRESSURE_LIMIT_RST = 12'd3900;
    localparam logic [8:0]  SPREAD_LIMIT_RST   = 9'd10;

    // Configuration register indexes
    localparam logic [0:0] REG_PRESSURE_LIMIT = 1'b0;
    localparam logic [0:0] REG_SPREAD_LIMIT   = 1'b1;

    typedef logic [RD_W-1:0]          reading_t;
    typedef reading_t [NUM_RD-1:0]    reading_arr_t;
    typedef logic [8:0]               coord_t;
    typedef logic [MAG_W-1:0]         mag_t;
    typedef logic [QUOT_W-1:0]        quot_t;

    typedef enum logic [1:0] {
        CH_Z1 = 2'd0,
        CH_Z2 = 2'd1,
        CH_X  = 2'd2,
        CH_Y  = 2'd3
    } chan_t;

    // Stage load strobes for the scaling pipeline
    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } adv_t;

endpackage

`default_nettype wire

// File: hw/rtl/tmpf_rank_lane.sv
// One median lane: rank of its own reading among the other four.
// Depends on tmpf_pkg.
`default_nettype none

module tmpf_rank_lane
    import tmpf_pkg::*;
(
    input  reading_t                own,
    input  reading_t [NUM_RD-2:0]   others,
    input  logic     [NUM_RD-2:0]   earlier,   // other lane sits at a lower index
    output logic                    is_mid
);

    logic [NUM_RD-2:0] beats;
    logic [RANK_W-1:0] rank;

    // ties go to the lower index, so ranks form a strict order
    always_comb begin
        rank = '0;
        for (int j = 0; j < NUM_RD - 1; j++) begin
            beats[j] = earlier[j] ? (others[j] <= own) : (others[j] < own);
            rank     = rank + RANK_W'(beats[j]);
        end
    end

    assign is_mid = (rank == MID_RANK);

endmodule

`default_nettype wire

// File: hw/rtl/tmpf_median.sv
// Median of five readings: one rank lane per reading, merged by one-hot select.
// Depends on tmpf_pkg and tmpf_rank_lane.
`default_nettype none

module tmpf_median
    import tmpf_pkg::*;
(
    input  reading_arr_t readings,
    output reading_t     median
);

    logic [NUM_RD-1:0] sel;

    for (genvar g = 0; g < NUM_RD; g++) begin : g_lane
        reading_t [NUM_RD-2:0] others;
        logic     [NUM_RD-2:0] earlier;

        always_comb begin
            for (int j = 0; j < NUM_RD - 1; j++) begin
                if (j < g) begin
                    others[j]  = readings[j];
                    earlier[j] = 1'b1;
                end else begin
                    others[j]  = readings[j+1];
                    earlier[j] = 1'b0;
                end
            end
        end

        tmpf_rank_lane u_lane (
            .own     (readings[g]),
            .others  (others),
            .earlier (earlier),
            .is_mid  (sel[g])
        );
    end

    // exactly one lane holds the middle rank
    always_comb begin
        median = '0;
        for (int i = 0; i < NUM_RD; i++) begin
            median = median | (readings[i] & {RD_W{sel[i]}});
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tmpf_scale.sv
// Scales one axis reading to pixels: (operand - offset) * scale / SPAN, toward zero,
// plus the off-screen check. Three stages. Depends on tmpf_pkg.
`default_nettype none

module tmpf_scale
    import tmpf_pkg::*;
(
    input  logic        aclk,
    input  adv_t        adv,
    input  reading_t    operand,
    input  reading_t    offset,
    input  logic [11:0] scale,       // also the largest on-screen coordinate
    output logic        off_screen,
    output coord_t      coord
);

    logic [RD_W:0]     diff;
    logic [RD_W:0]     abs_full;
    logic              neg_next;
    mag_t              mag_next;
    logic [PROD_W-1:0] prod;
    quot_t             q0_next;
    mag_t              back;
    mag_t              rem;
    quot_t             quot;
    logic              off_next;
    coord_t            coord_next;

    logic   neg2_reg, neg3_reg;
    mag_t   mag2_reg, mag3_reg;
    quot_t  q0_reg;
    logic   off_reg;
    coord_t coord_reg;

    // stage 2: sign and magnitude of the product
    always_comb begin
        diff     = {1'b0, operand} - {1'b0, offset};
        neg_next = diff[RD_W];
        abs_full = neg_next ? ((RD_W+1)'(0) - diff) : diff;
        mag_next = MAG_W'(abs_full[RD_W-1:0]) * MAG_W'(scale);
    end

    // stage 3: reciprocal estimate, low by at most one
    always_comb begin
        prod    = PROD_W'(mag2_reg) * PROD_W'(RECIP);
        q0_next = prod[RECIP_SHIFT +: QUOT_W];
    end

    // stage 4: correction and range check
    always_comb begin
        back       = MAG_W'(q0_reg) * MAG_W'(SPAN);
        rem        = mag3_reg - back;
        quot       = q0_reg + QUOT_W'(rem >= MAG_W'(SPAN));
        off_next   = neg3_reg ? (quot != '0) : (quot > QUOT_W'(scale));
        coord_next = neg3_reg ? '0 : quot[8:0];
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            neg2_reg <= neg_next;
            mag2_reg <= mag_next;
        end
        if (adv.s3) begin
            neg3_reg <= neg2_reg;
            mag3_reg <= mag2_reg;
            q0_reg   <= q0_next;
        end
        if (adv.s4) begin
            off_reg   <= off_next;
            coord_reg <= coord_next;
        end
    end

    assign off_screen = off_reg;
    assign coord      = coord_reg;

endmodule

`default_nettype wire

// File: hw/rtl/touch_median_press_filter_core.sv
// Resistive touch press filter, top level.
// Depends on tmpf_pkg, tmpf_median, tmpf_scale.
//
// Input stream (s_): one transaction per converter channel. s_tuser carries the
// channel (0 z1, 1 z2, 2 x, 3 y), s_tdata the five raw readings. The median of
// the five is taken. z1 and x are held and produce nothing; a z2 whose pressure
// difference exceeds the limit produces a not-pressed result; a y is scaled with
// the held x, range checked and folded into a group of samples, producing one
// result per y transaction.
// Output stream (m_): m_tuser = pressed, m_tdata = pos_x, pos_y (zero unless pressed).
// Config channel: cfg_index 0 = pressure limit, 1 = spread limit; cfg_ready is
// always high. Write only while no transaction is in flight.
// Throughput: one transaction per cycle while the receiver keeps up. Five register
// stages, the first loaded at the accepting edge: median, axis product, reciprocal
// multiply, quotient correction, group filter and output.
// Reset (aresetn low, synchronous): pipeline emptied, m_tvalid low, limits back
// to 3900 and 10, held values and group state cleared.
// Receiver stall: the output register holds its result; upstream stages keep
// accepting until every bubble is filled, then s_tready drops.
`default_nettype none

module touch_median_press_filter_core
    import tmpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // reading_0 [11:0] .. reading_4 [59:48], zero pad
    input  logic [1:0]  s_tuser,    // channel [1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // pos_x [8:0], pos_y [17:9], zero pad
    output logic        m_tuser,    // pressed [0]
    // config writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    // ---------------------------------------------------------------
    // Config registers
    // ---------------------------------------------------------------
    logic [11:0] pressure_limit_reg;
    logic [8:0]  spread_limit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressure_limit_reg <= PRESSURE_LIMIT_RST;
            spread_limit_reg   <= SPREAD_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PRESSURE_LIMIT: pressure_limit_reg <= cfg_data;
                REG_SPREAD_LIMIT:   spread_limit_reg   <= cfg_data[8:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline flow control: a stage moves when the next one is free
    // ---------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic m_tvalid_reg;
    logic out_free, free4, free3, free2, free1;
    logic load1, adv_out;
    adv_t adv;

    assign out_free = !m_tvalid_reg || m_tready;
    assign free4    = !s4_valid_reg || out_free;
    assign free3    = !s3_valid_reg || free4;
    assign free2    = !s2_valid_reg || free3;
    assign free1    = !s1_valid_reg || free2;

    assign s_tready = free1;
    assign load1    = s_tvalid && s_tready;
    assign adv.s2   = s1_valid_reg && free2;
    assign adv.s3   = s2_valid_reg && free3;
    assign adv.s4   = s3_valid_reg && free4;
    assign adv_out  = s4_valid_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= (s1_valid_reg && !adv.s2) || load1;
            s2_valid_reg <= (s2_valid_reg && !adv.s3) || adv.s2;
            s3_valid_reg <= (s3_valid_reg && !adv.s4) || adv.s3;
            s4_valid_reg <= (s4_valid_reg && !adv_out) || adv.s4;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: median of the five readings
    // ---------------------------------------------------------------
    reading_arr_t readings;
    reading_t     median;
    chan_t        s1_ch_reg;
    reading_t     s1_med_reg;

    always_comb begin
        for (int i = 0; i < NUM_RD; i++) begin
            readings[i] = s_tdata[i*RD_W +: RD_W];
        end
    end

    tmpf_median u_median (
        .readings (readings),
        .median   (median)
    );

    always_ff @(posedge aclk) begin
        if (load1) begin
            s1_ch_reg  <= chan_t'(s_tuser);
            s1_med_reg <= median;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: held values, pressure check, start of axis scaling
    // ---------------------------------------------------------------
    reading_t      held_z1_reg, held_x_reg;
    logic [RD_W:0] z_diff;
    logic          rel_next;
    chan_t         s2_ch_reg, s3_ch_reg, s4_ch_reg;
    logic          s2_rel_reg, s3_rel_reg, s4_rel_reg;

    // signed z2 - z1 against the limit
    always_comb begin
        z_diff   = {1'b0, s1_med_reg} - {1'b0, held_z1_reg};
        rel_next = (s1_ch_reg == CH_Z2) &&
                   ($signed(z_diff) > $signed({1'b0, pressure_limit_reg}));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_z1_reg <= '0;
            held_x_reg  <= '0;
        end else if (adv.s2) begin
            if (s1_ch_reg == CH_Z1) held_z1_reg <= s1_med_reg;
            if (s1_ch_reg == CH_X)  held_x_reg  <= s1_med_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.s2) begin
            s2_ch_reg  <= s1_ch_reg;
            s2_rel_reg <= rel_next;
        end
        if (adv.s3) begin
            s3_ch_reg  <= s2_ch_reg;
            s3_rel_reg <= s2_rel_reg;
        end
        if (adv.s4) begin
            s4_ch_reg  <= s3_ch_reg;
            s4_rel_reg <= s3_rel_reg;
        end
    end

    // stages 2 to 4: pixel scaling of both axes
    logic   off_x, off_y;
    coord_t coord_x, coord_y;

    tmpf_scale u_scale_x (
        .aclk       (aclk),
        .adv        (adv),
        .operand    (held_x_reg),
        .offset     (X_OFFSET),
        .scale      (SCREEN_WIDTH),
        .off_screen (off_x),
        .coord      (coord_x)
    );

    tmpf_scale u_scale_y (
        .aclk       (aclk),
        .adv        (adv),
        .operand    (s1_med_reg),
        .offset     (Y_OFFSET),
        .scale      (SCREEN_HEIGHT),
        .off_screen (off_y),
        .coord      (coord_y)
    );

    // ---------------------------------------------------------------
    // Stage 5: group filter and output register
    // ---------------------------------------------------------------
    logic [2:0] cnt_reg, cnt_next, cnt_inc;
    logic       touched_reg, touched_next;
    coord_t     min_x_reg, max_x_reg, min_y_reg, max_y_reg;
    coord_t     min_x_next, max_x_next, min_y_next, max_y_next;
    coord_t     last_x_reg, last_y_reg, last_x_next, last_y_next;
    coord_t     spread_x, spread_y;
    logic       emit, pressed;
    logic [23:0] m_tdata_reg;
    logic        m_tuser_reg;

    always_comb begin
        cnt_next     = cnt_reg;
        touched_next = touched_reg;
        min_x_next   = min_x_reg;
        max_x_next   = max_x_reg;
        min_y_next   = min_y_reg;
        max_y_next   = max_y_reg;
        last_x_next  = last_x_reg;
        last_y_next  = last_y_reg;
        cnt_inc      = cnt_reg + 3'd1;
        spread_x     = '0;
        spread_y     = '0;
        emit         = 1'b0;
        pressed      = 1'b0;

        unique case (s4_ch_reg)
            CH_Z2: begin
                if (s4_rel_reg) begin
                    emit         = 1'b1;
                    cnt_next     = '0;
                    touched_next = 1'b0;
                end
            end
            CH_Y: begin
                emit = 1'b1;
                if (off_x || off_y) begin
                    cnt_next     = '0;
                    touched_next = 1'b0;
                end else begin
                    if (cnt_reg == '0) begin
                        min_x_next = coord_x;
                        max_x_next = coord_x;
                        min_y_next = coord_y;
                        max_y_next = coord_y;
                    end else begin
                        if (coord_x < min_x_reg) min_x_next = coord_x;
                        if (coord_x > max_x_reg) max_x_next = coord_x;
                        if (coord_y < min_y_reg) min_y_next = coord_y;
                        if (coord_y > max_y_reg) max_y_next = coord_y;
                    end
                    spread_x = max_x_next - min_x_next;
                    spread_y = max_y_next - min_y_next;
                    if (cnt_inc < GROUP_SIZE) begin
                        // mid group: repeat the last report
                        cnt_next = cnt_inc;
                        pressed  = touched_reg;
                    end else begin
                        cnt_next = '0;
                        if (spread_x > spread_limit_reg || spread_y > spread_limit_reg) begin
                            touched_next = 1'b0;
                        end else begin
                            last_x_next  = min_x_next + (spread_x >> 1);
                            last_y_next  = min_y_next + (spread_y >> 1);
                            touched_next = 1'b1;
                            pressed      = 1'b1;
                        end
                    end
                end
            end
            CH_Z1, CH_X: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            touched_reg <= 1'b0;
            min_x_reg   <= '0;
            max_x_reg   <= '0;
            min_y_reg   <= '0;
            max_y_reg   <= '0;
            last_x_reg  <= '0;
            last_y_reg  <= '0;
        end else if (adv_out) begin
            cnt_reg     <= cnt_next;
            touched_reg <= touched_next;
            min_x_reg   <= min_x_next;
            max_x_reg   <= max_x_next;
            min_y_reg   <= min_y_next;
            max_y_reg   <= max_y_next;
            last_x_reg  <= last_x_next;
            last_y_reg  <= last_y_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv_out) begin
            m_tvalid_reg <= emit;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && emit) begin
            m_tuser_reg <= pressed;
            m_tdata_reg <= pressed ? {6'd0, last_y_next, last_x_next} : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// File: hw/rtl/tmpf_checker.sv
// Port-level checks on the press filter result stream, bound to the top level.
// Depends on tmpf_pkg and touch_median_press_filter_core.
`default_nettype none

module tmpf_checker
    import tmpf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser
);

    // stalled result stays offered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // reset empties the output
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // not-pressed reports carry a zero position
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("non-zero position without press");

    // a pressed position is on screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            ({3'd0, m_tdata[8:0]} <= SCREEN_WIDTH) &&
            ({3'd0, m_tdata[17:9]} <= SCREEN_HEIGHT) && (m_tdata[23:18] == 6'd0))
        else $error("pressed position off screen");

endmodule

bind touch_median_press_filter_core tmpf_checker u_tmpf_checker (.*);

`default_nettype wire

// File: tb/sv/touch_median_press_filter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for touch_median_press_filter_core: directed edge cases, limit
// register sweeps and random touch traffic, checked against an in-bench press predictor.
// Depends on tmpf_pkg and the core RTL only.

module touch_median_press_filter_core_tb;
    import tmpf_pkg::*;

    localparam int CYCLE_LIMIT   = 500_000;
    localparam int SETTLE_CYCLES = 12;      // keep a margin over the pipeline latency

    typedef struct packed {
        logic   pressed;
        coord_t pos_x;
        coord_t pos_y;
    } touch_report_t;

    // DUT ports, all inputs driven to known values from time zero
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [11:0] cfg_data  = '0;

    // Predictor copy of the limits and the filter state
    logic [11:0] lim_pressure = PRESSURE_LIMIT_RST;
    logic [8:0]  lim_spread   = SPREAD_LIMIT_RST;
    reading_t    pz1_hold     = '0;
    reading_t    xraw_hold    = '0;
    logic [2:0]  group_fill   = '0;
    coord_t      x_lo = '0, x_hi = '0, y_lo = '0, y_hi = '0;
    coord_t      x_report = '0, y_report = '0;
    logic        touch_active = 1'b0;

    touch_report_t expected_reports[$];
    int          items_sent     = 0;
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          sink_wait      = 0;
    bit          no_idle        = 1'b0;   // when set, neither side inserts gaps

    touch_median_press_filter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Press predictor
    // ------------------------------------------------------------------
    function automatic void order_pair(inout reading_t a, inout reading_t b);
        reading_t t;
        if (a > b) begin
            t = a;
            a = b;
            b = t;
        end
    endfunction

    // Updates the predictor state for one accepted transaction and queues the
    // report it should produce, if any.
    function automatic void predict_touch_report(chan_t ch, reading_arr_t rd);
        reading_t      v [NUM_RD];
        reading_t      mid;
        int            sx, sy;
        coord_t        cx, cy;
        bit            emits;
        touch_report_t rep;
        for (int i = 0; i < NUM_RD; i++) v[i] = rd[i];
        // nine-stage compare-exchange network; the hardware ranks each reading instead
        order_pair(v[0], v[1]);
        order_pair(v[2], v[3]);
        order_pair(v[0], v[2]);
        order_pair(v[1], v[4]);
        order_pair(v[0], v[1]);
        order_pair(v[2], v[3]);
        order_pair(v[1], v[2]);
        order_pair(v[3], v[4]);
        order_pair(v[2], v[3]);
        mid   = v[2];
        rep   = '0;
        emits = 1'b0;
        case (ch)
            CH_Z1: pz1_hold = mid;
            CH_X:  xraw_hold = mid;
            CH_Z2: begin
                // signed pressure difference against the held z1
                if (int'(mid) - int'(pz1_hold) > int'(lim_pressure)) begin
                    group_fill   = '0;
                    touch_active = 1'b0;
                    emits        = 1'b1;
                end
            end
            default: begin
                // signed scaling, division truncates toward zero
                sx = (int'(xraw_hold) - int'(X_OFFSET)) * int'(SCREEN_WIDTH) / int'(SPAN);
                sy = (int'(mid) - int'(Y_OFFSET)) * int'(SCREEN_HEIGHT) / int'(SPAN);
                emits = 1'b1;
                if (sx < 0 || sx > int'(SCREEN_WIDTH) || sy < 0 || sy > int'(SCREEN_HEIGHT)) begin
                    group_fill   = '0;
                    touch_active = 1'b0;
                end else begin
                    cx = coord_t'(sx);
                    cy = coord_t'(sy);
                    if (group_fill == 3'd0) begin
                        x_lo = cx;
                        x_hi = cx;
                        y_lo = cy;
                        y_hi = cy;
                    end else begin
                        if (cx < x_lo) x_lo = cx;
                        if (cx > x_hi) x_hi = cx;
                        if (cy < y_lo) y_lo = cy;
                        if (cy > y_hi) y_hi = cy;
                    end
                    group_fill = group_fill + 3'd1;
                    if (group_fill < GROUP_SIZE) begin
                        // mid group: repeat the last verdict
                        if (touch_active) rep = '{1'b1, x_report, y_report};
                    end else begin
                        group_fill = '0;
                        if (x_hi - x_lo > lim_spread || y_hi - y_lo > lim_spread) begin
                            touch_active = 1'b0;
                        end else begin
                            x_report     = x_lo + (x_hi - x_lo) / 2;
                            y_report     = y_lo + (y_hi - y_lo) / 2;
                            touch_active = 1'b1;
                            rep          = '{1'b1, x_report, y_report};
                        end
                    end
                end
            end
        endcase
        if (emits) expected_reports.push_back(rep);
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls and the scoreboard check
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        touch_report_t exp_rep;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            sink_wait = 0;
        end else begin
            if (m_tvalid === 1'b1 && m_tready) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected result: pressed=%0b pos_x=%0d pos_y=%0d",
                           m_tuser, m_tdata[8:0], m_tdata[17:9]);
                    mismatch_count++;
                end else begin
                    exp_rep = expected_reports.pop_front();
                    if (m_tuser !== exp_rep.pressed) begin
                        $error("pressed: expected %0b, actual %0b", exp_rep.pressed, m_tuser);
                        mismatch_count++;
                    end
                    if (m_tdata[8:0] !== exp_rep.pos_x) begin
                        $error("pos_x: expected %0d, actual %0d", exp_rep.pos_x, m_tdata[8:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[17:9] !== exp_rep.pos_y) begin
                        $error("pos_y: expected %0d, actual %0d", exp_rep.pos_y, m_tdata[17:9]);
                        mismatch_count++;
                    end
                end
                sink_wait = no_idle ? 0 : $urandom_range(0, 14);
            end else if (sink_wait > 0) begin
                sink_wait--;
            end
            m_tready <= (sink_wait == 0);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Five readings around base, with an occasional wild reading that the
    // median should reject.
    function automatic reading_arr_t readings_near(int base, int jitter);
        reading_arr_t rd;
        int           v;
        for (int i = 0; i < NUM_RD; i++) begin
            v = base + int'($urandom_range(0, 2 * jitter)) - jitter;
            if (v < 0) v = 0;
            else if (v > 4095) v = 4095;
            rd[i] = reading_t'(v);
        end
        if ($urandom_range(0, 3) == 0) rd[$urandom_range(0, 4)] = reading_t'($urandom_range(0, 4095));
        return rd;
    endfunction

    // One input transaction. Valid is only lowered when a gap precedes it, so a
    // back-to-back transaction never sees two assignments in one step.
    task automatic send_item(chan_t ch, reading_arr_t rd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= {4'b0, rd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_touch_report(ch, rd);
        items_sent++;
    endtask

    // Waits until the block holds no work, so limits may change.
    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        // z1, x and quiet z2 transactions leave no report behind
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(logic [0:0] idx, logic [11:0] value);
        drain_pipeline();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == REG_PRESSURE_LIMIT) lim_pressure = value;
        else lim_spread = value[8:0];
    endtask

    // A complete touch sample: optional pressure pair, then x and y.
    task automatic send_touch_sample(int z1b, int z2b, int xb, int yb, int jit, bit with_press);
        if (with_press) begin
            send_item(CH_Z1, readings_near(z1b, 10));
            send_item(CH_Z2, readings_near(z2b, 10));
        end
        send_item(CH_X, readings_near(xb, jit));
        send_item(CH_Y, readings_near(yb, jit));
    endtask

    // Runs of samples around one finger position, mixed with noise.
    task automatic send_random_traffic(int n_items);
        int stop_at, xb, yb, z1b, z2b, jit, run_len;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) no_idle = ~no_idle;
            if ($urandom_range(0, 7) == 0) begin
                // noise: any channel, readings anywhere in range
                send_item(chan_t'($urandom_range(0, 3)), readings_near(2048, 2048));
            end else begin
                xb = $urandom_range(200, 4000);
                yb = $urandom_range(120, 3900);
                case ($urandom_range(0, 4))
                    0:       jit = 0;
                    1:       jit = 3;
                    2:       jit = 12;
                    3:       jit = 40;
                    default: jit = 300;
                endcase
                run_len = $urandom_range(1, 12);
                repeat (run_len) begin
                    z1b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 150)
                                                      : $urandom_range(0, 2500);
                    if ($urandom_range(0, 3) == 0) z2b = $urandom_range(0, 4095);
                    else z2b = z1b + int'($urandom_range(0, 300)) - 150;
                    send_touch_sample(z1b, z2b, xb, yb, jit, $urandom_range(0, 4) != 0);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes and bit patterns at reset limits.
    task automatic test_field_extremes();
        send_item(CH_Y, readings_near(2000, 0));   // y with nothing held: x of zero is off screen
        send_item(CH_Z1, '0);
        send_item(CH_Z2, readings_near(4095, 0));  // full pressure difference, release
        send_item(CH_Z1, readings_near(4095, 0));
        send_item(CH_Z2, '0);                      // negative difference, no report
        send_item(CH_X, readings_near(4095, 0));
        send_item(CH_Y, '0);                       // both axes off screen
        send_item(CH_X, {12'h555, 12'hAAA, 12'hFFF, 12'h000, 12'hAAA});
        send_item(CH_Y, {12'hAAA, 12'h555, 12'h000, 12'hFFF, 12'h555});
    endtask

    // Screen corners, truncation just below the offsets and one pixel past the edges.
    task automatic test_screen_edges();
        send_item(CH_Y, '0);                                         // y below offset: clears group
        send_item(CH_X, readings_near(3900, 0));
        repeat (GROUP_SIZE) send_item(CH_Y, readings_near(3800, 0));  // touch at far corner
        send_item(CH_X, readings_near(293, 0));                      // truncates to zero
        repeat (GROUP_SIZE) send_item(CH_Y, readings_near(195, 0));  // repeats corner, then origin
        send_item(CH_X, readings_near(3908, 0));
        send_item(CH_Y, readings_near(3800, 0));                     // one pixel past right edge
        send_item(CH_X, readings_near(3900, 0));
        send_item(CH_Y, readings_near(3812, 0));                     // one pixel past bottom edge
    endtask

    // Sweeps both limits through their extremes and a couple of typical values.
    task automatic test_limit_settings();
        logic [11:0] press_set  [4];
        logic [11:0] spread_set [4];
        press_set  = '{12'd0, 12'd4095, 12'd1200, PRESSURE_LIMIT_RST};
        spread_set = '{12'd0, 12'd480, 12'd3, 12'(SPREAD_LIMIT_RST)};
        for (int k = 0; k < 4; k++) begin
            write_limit(REG_PRESSURE_LIMIT, press_set[k]);
            write_limit(REG_SPREAD_LIMIT, spread_set[k]);
            send_random_traffic(40);
        end
    endtask

    // Bulk random traffic with a new pair of limits after at least seventy-six transactions.
    task automatic test_random_traffic();
        repeat (5) begin
            write_limit(REG_PRESSURE_LIMIT, ($urandom_range(0, 1) == 0)
                        ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(3000, 4095)));
            write_limit(REG_SPREAD_LIMIT, 12'($urandom_range(0, 480)));
            send_random_traffic(76);
        end
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_screen_edges();
        test_limit_settings();
        test_random_traffic();
        drain_pipeline();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
